// ===== src/apa_pkg.sv =====
package apa_pkg;

    localparam int FRAMES_W = 13;
    localparam int TIME_W   = 64;
    localparam int COUNT_W  = 64;
    localparam int TARGET_W = 32;
    localparam int RATE_W   = 18;
    localparam int MS_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int APA_QUEUE_DEPTH = 2;

    localparam logic [29:0]         NS_PER_S         = 30'd1000000000;
    localparam logic [19:0]         NS_PER_MS        = 20'd1000000;
    localparam logic [TIME_W-1:0]   LATE_LIMIT_NS    = 64'd250000000;
    localparam logic [TIME_W-1:0]   QUIET_SPAN_NS    = 64'd5000000000;
    localparam logic [TARGET_W-1:0] TARGET_CEIL_NS   = 32'd400000000;
    localparam logic [TARGET_W-1:0] TARGET_STEP_NS   = 32'd40000000;
    localparam logic [TARGET_W-1:0] TARGET_FLOOR_NS  = 32'd60000000;
    localparam logic [TARGET_W-1:0] TARGET_SHRINK_NS = 32'd10000000;
    localparam logic [TARGET_W-1:0] TARGET_RESET_NS  = 32'd60000000;
    localparam logic [RATE_W-1:0]   RATE_RESET       = 18'd48000;
    localparam logic [MS_W-1:0]     PINNED_RESET_MS  = 12'd60;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_OPEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PACING_OFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PINNED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PINNED_MS     = 3'd4;

    typedef struct packed {
        logic [FRAMES_W-1:0] frames;
        logic [TIME_W-1:0]   now_ns;
        logic                queue_empty;
    } push_t;

    typedef struct packed {
        logic                wait_needed;
        logic [TIME_W-1:0]   wake_ns;
        logic                reanchored;
        logic [TARGET_W-1:0] latency_target_ns;
        logic [COUNT_W-1:0]  pushed_count;
        logic [COUNT_W-1:0]  dropped_count;
        logic [COUNT_W-1:0]  underrun_count;
    } result_t;

    typedef struct packed {
        logic              device_open;
        logic [RATE_W-1:0] sample_rate;
        logic              pacing_off;
        logic              target_pinned;
        logic [MS_W-1:0]   pinned_target_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_IGNORE = 2'd0,
        CMD_DROP   = 2'd1,
        CMD_PUSH   = 2'd2,
        CMD_PACE   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [FRAMES_W-1:0] frames;
        logic [TIME_W-1:0]   now_ns;
        logic                queue_empty;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

endpackage

// ===== src/apa_front.sv =====
module apa_front
    import apa_pkg::*;
#(
    parameter int QUEUE_DEPTH = APA_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      push_valid,
    output logic      push_stall,
    input  push_t     push,
    output cmd_slot_t head,
    input  logic      pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             accept;
    logic             take;
    cmd_t             cmd_in;

    always_comb
    begin
        cmd_in.frames      = push.frames;
        cmd_in.now_ns      = push.now_ns;
        cmd_in.queue_empty = push.queue_empty;
        if (push.frames == '0)
        begin
            cmd_in.kind = CMD_IGNORE;
        end
        else if (!cfg.device_open)
        begin
            cmd_in.kind = CMD_DROP;
        end
        else if (cfg.pacing_off || cfg.sample_rate == '0)
        begin
            cmd_in.kind = CMD_PUSH;
        end
        else
        begin
            cmd_in.kind = CMD_PACE;
        end
    end

    assign push_stall = (count_reg == FULL_CNT);
    assign accept     = push_valid && !push_stall;
    assign take       = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (accept && !take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (take && !accept)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/apa_div.sv =====
module apa_div
    import apa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [RATE_W-1:0] divisor,
    output logic              done,
    output logic [TIME_W-1:0] quotient
);

    localparam int STEP_W = $clog2(TIME_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

    logic [TIME_W-1:0] quot_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;
    logic              fits;

    assign trial    = {rem_reg, quot_reg[TIME_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign fits     = (trial >= {1'b0, divisor});
    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[TIME_W-2:0], fits};
            rem_reg  <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/apa_back.sv =====
module apa_back
    import apa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_slot_t head,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output result_t   result
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MUL_LO = 10'b0000000010,
        S_MUL_HI = 10'b0000000100,
        S_DIV_GO = 10'b0000001000,
        S_DIV    = 10'b0000010000,
        S_SUM    = 10'b0000100000,
        S_FLOOR  = 10'b0001000000,
        S_CMP    = 10'b0010000000,
        S_APPLY  = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [COUNT_W-1:0]  pushed_reg;
    logic [COUNT_W-1:0]  dropped_reg;
    logic [COUNT_W-1:0]  underrun_reg;
    logic [COUNT_W-1:0]  paced_reg;
    logic [TIME_W-1:0]   origin_reg;
    logic                origin_set_reg;
    logic [TARGET_W-1:0] target_reg;
    logic                pending_reg;
    logic [TIME_W-1:0]   last_adj_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   prod_reg;
    logic [TIME_W-1:0]   due_reg;
    logic [TIME_W-1:0]   diff_reg;
    logic                early_reg;
    logic                quiet_reg;
    logic                wait_reg;
    logic                moved_reg;
    logic [TARGET_W-1:0] pin_ns_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic [61:0]         mul_lo;
    logic [31:0]         mul_hi;
    logic [TARGET_W-1:0] tgt;
    logic [TIME_W-1:0]   frames_ext;
    logic                div_start;
    logic                div_done;
    logic [TIME_W-1:0]   quotient;
    logic                slot_free;

    apa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (cfg.sample_rate),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mul_lo     = {30'b0, paced_reg[31:0]} * {32'b0, NS_PER_S};
    assign mul_hi     = paced_reg[63:32] * {2'b0, NS_PER_S};
    assign tgt        = cfg.target_pinned ? pin_ns_reg : target_reg;
    assign frames_ext = {{(TIME_W - FRAMES_W){1'b0}}, head.cmd.frames};
    assign div_start  = (state_reg == S_DIV_GO);
    assign pop        = (state_reg == S_IDLE) && head.valid;
    assign slot_free  = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.cmd.kind == CMD_PACE && origin_set_reg)
                    begin
                        state_next = S_MUL_LO;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_DIV_GO;
            S_DIV_GO: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:   state_next = S_FLOOR;
            S_FLOOR: state_next = S_CMP;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: state_next = S_EMIT;
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        pin_ns_reg <= {20'b0, cfg.pinned_target_ms} * {12'b0, NS_PER_MS};
        unique case (state_reg)
            S_IDLE:   now_reg  <= head.cmd.now_ns;
            S_MUL_LO: prod_reg <= {2'b0, mul_lo};
            S_MUL_HI: prod_reg <= prod_reg + {mul_hi, 32'b0};
            S_SUM:    due_reg  <= origin_reg + quotient;
            S_FLOOR:  due_reg  <= (due_reg > {32'b0, tgt}) ? due_reg - {32'b0, tgt} : '0;
            S_CMP:
            begin
                early_reg <= (now_reg < due_reg);
                diff_reg  <= now_reg - due_reg;
                quiet_reg <= ((now_reg - last_adj_reg) > QUIET_SPAN_NS);
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EMIT && slot_free)
        begin
            out_reg.wait_needed       <= wait_reg;
            out_reg.wake_ns           <= wait_reg ? due_reg : '0;
            out_reg.reanchored        <= moved_reg;
            out_reg.latency_target_ns <= tgt;
            out_reg.pushed_count      <= pushed_reg;
            out_reg.dropped_count     <= dropped_reg;
            out_reg.underrun_count    <= underrun_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pushed_reg     <= '0;
            dropped_reg    <= '0;
            underrun_reg   <= '0;
            paced_reg      <= '0;
            origin_reg     <= '0;
            origin_set_reg <= 1'b0;
            target_reg     <= TARGET_RESET_NS;
            pending_reg    <= 1'b0;
            last_adj_reg   <= '0;
            wait_reg       <= 1'b0;
            moved_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    wait_reg  <= 1'b0;
                    moved_reg <= 1'b0;
                    if (head.valid)
                    begin
                        case (head.cmd.kind) inside
                            CMD_DROP:
                            begin
                                dropped_reg <= dropped_reg + frames_ext;
                            end
                            CMD_PUSH, CMD_PACE:
                            begin
                                pushed_reg <= pushed_reg + frames_ext;
                                if (head.cmd.queue_empty)
                                begin
                                    underrun_reg <= underrun_reg + 64'd1;
                                    pending_reg  <= 1'b1;
                                end
                                if (head.cmd.kind == CMD_PACE)
                                begin
                                    paced_reg <= paced_reg + frames_ext;
                                    if (!origin_set_reg)
                                    begin
                                        origin_reg     <= head.cmd.now_ns;
                                        origin_set_reg <= 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_APPLY:
                begin
                    if (early_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (diff_reg > LATE_LIMIT_NS)
                    begin
                        origin_reg <= origin_reg + diff_reg;
                        moved_reg  <= 1'b1;
                    end
                    if (!cfg.target_pinned)
                    begin
                        if (pending_reg)
                        begin
                            pending_reg  <= 1'b0;
                            last_adj_reg <= now_reg;
                            if (target_reg < TARGET_CEIL_NS)
                            begin
                                target_reg <= target_reg + TARGET_STEP_NS;
                            end
                        end
                        else if (quiet_reg && target_reg > TARGET_FLOOR_NS)
                        begin
                            target_reg   <= target_reg - TARGET_SHRINK_NS;
                            last_adj_reg <= now_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== src/audio_push_pacer.sv =====
// Paces an audio producer against the output device clock. Each push request
// carries a frame count, the current time and the device queue state, and
// yields exactly one result request with the wait decision, the latency target
// and the running frame and underrun totals.
// Push requests enter on push_valid/push_stall into a short command queue;
// push_stall rises only while that queue is full, so a new push is taken even
// while a finished result still waits for the receiver.
// On an otherwise idle block, an empty, dropped, unpaced or anchoring push goes
// from S_IDLE straight to S_EMIT. Any other paced push also passes S_MUL_LO,
// S_MUL_HI, S_DIV_GO and S_DIV, where the 64-step restoring divider divides the
// frame time product by the sample rate, then S_SUM, S_FLOOR, S_CMP and S_APPLY.
// The back end takes a new push only after it has emitted the last result.
// The configuration port writes one register per cycle at cfg_index; the user
// must use it only while the block is idle, and the block does not enforce this.
// Reset clears all totals and the pacing origin, restores the default
// configuration and sets the latency target to 60 ms. While the receiver
// holds result_stall, the result stays unchanged on the port; the next push is
// still taken from the queue, and its result waits in S_EMIT.
module audio_push_pacer
    import apa_pkg::*;
#(
    parameter int QUEUE_DEPTH = APA_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push_valid,
    output logic                  push_stall,
    input  push_t                 push,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    cfg_t      cfg_reg;
    cmd_slot_t head;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_open      <= 1'b0;
            cfg_reg.sample_rate      <= RATE_RESET;
            cfg_reg.pacing_off       <= 1'b0;
            cfg_reg.target_pinned    <= 1'b0;
            cfg_reg.pinned_target_ms <= PINNED_RESET_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEVICE_OPEN:   cfg_reg.device_open      <= cfg_data[0];
                REG_SAMPLE_RATE:   cfg_reg.sample_rate      <= cfg_data[RATE_W-1:0];
                REG_PACING_OFF:    cfg_reg.pacing_off       <= cfg_data[0];
                REG_TARGET_PINNED: cfg_reg.target_pinned    <= cfg_data[0];
                REG_PINNED_MS:     cfg_reg.pinned_target_ms <= cfg_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    apa_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push       (push),
        .head       (head),
        .pop        (pop)
    );

    apa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_wait_has_deadline: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.wait_needed |-> result.wake_ns != '0)
        else $error("wait requested with a zero deadline");

    a_no_wake_without_wait: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.wait_needed |-> result.wake_ns == '0)
        else $error("deadline reported without a wait");

    a_wait_or_reanchor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.wait_needed && result.reanchored))
        else $error("wait and reanchor in the same result");

    a_pop_only_with_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("command taken from an empty queue");
`endif

endmodule
